/* sv/sfia_pkg.sv */
// ----------------------------------------------------------------------------
// sfia_pkg: shared types and constants of the smallest free id allocator
// Field widths, heap sizing, request kinds, status codes and the control
// structs that run between the top level and the heap engine.
// ----------------------------------------------------------------------------
package sfia_pkg;

	localparam int MAX_SEATS = 1024;
	localparam int SEAT_W    = 11;
	localparam int IDX_W     = $clog2(MAX_SEATS);
	localparam int CNT_W     = IDX_W + 1;
	localparam int LIM_W     = (CNT_W > SEAT_W) ? CNT_W : SEAT_W;

	localparam logic MODE_RESERVE = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_HEAP_FULL = 2'd2;

	typedef struct packed {
		logic              start;
		logic              pop;
		logic [SEAT_W-1:0] value;
	} heap_cmd_t;

	typedef struct packed {
		logic              done;
		logic [SEAT_W-1:0] value;
		logic [CNT_W-1:0]  count;
	} heap_rsp_t;

endpackage

/* sv/sfia_heap.sv */
// ----------------------------------------------------------------------------
// sfia_heap: min-heap engine
// Heap memory with two registered read ports and one write port, sifted
// up on push and down on pop by a small sequencer around one comparator.
// ----------------------------------------------------------------------------
module sfia_heap (
	input  logic                clk,
	input  logic                arst_n,
	input  sfia_pkg::heap_cmd_t cmd,
	output sfia_pkg::heap_rsp_t rsp
);
	import sfia_pkg::*;

	typedef enum logic [2:0] {
		H_IDLE,
		H_PUSH_CHK,
		H_PUSH_CMP,
		H_POP_RD,
		H_POP_LD,
		H_DN_CHK,
		H_DN_SEL,
		H_DN_CMP
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  pos_q;
	logic [IDX_W-1:0]  cidx_q;
	logic [CNT_W-1:0]  count_q;
	logic              done_q;
	logic [SEAT_W-1:0] val_q;
	logic [SEAT_W-1:0] top_q;
	logic [SEAT_W-1:0] last_q;
	logic [SEAT_W-1:0] cv_q;
	logic [SEAT_W-1:0] rd0_q;
	logic [SEAT_W-1:0] rd1_q;

	logic [SEAT_W-1:0] mem [MAX_SEATS];

	logic [IDX_W-1:0]  raddr0;
	logic [IDX_W-1:0]  raddr1;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [SEAT_W-1:0] wdata;
	logic [SEAT_W-1:0] cmp_a;
	logic [SEAT_W-1:0] cmp_b;
	logic              lt;
	logic [IDX_W-1:0]  parent;
	logic [CNT_W:0]    child;
	logic [CNT_W:0]    child_r;
	logic [CNT_W:0]    count_x;

	assign parent  = (pos_q - IDX_W'(1)) >> 1;
	assign child   = (CNT_W + 1)'({pos_q, 1'b1});
	assign child_r = child + (CNT_W + 1)'(1);
	assign count_x = (CNT_W + 1)'(count_q);

	// shared compare unit
	assign lt = cmp_a < cmp_b;

	always_comb begin
		raddr0 = '0;
		raddr1 = '0;
		we     = 1'b0;
		waddr  = pos_q;
		wdata  = val_q;
		cmp_a  = val_q;
		cmp_b  = rd0_q;
		case (state_q)
			H_PUSH_CHK: begin
				raddr0 = parent;
				we     = (pos_q == '0);
			end
			H_PUSH_CMP: begin
				we    = 1'b1;
				wdata = lt ? rd0_q : val_q;
			end
			H_POP_RD: begin
				raddr1 = count_q[IDX_W-1:0];
			end
			H_DN_CHK: begin
				raddr0 = child[IDX_W-1:0];
				raddr1 = child_r[IDX_W-1:0];
				we     = (child >= count_x) && (count_q != '0);
				wdata  = last_q;
			end
			H_DN_SEL: begin
				cmp_a = rd1_q;
				cmp_b = rd0_q;
			end
			H_DN_CMP: begin
				cmp_a = cv_q;
				cmp_b = last_q;
				we    = 1'b1;
				wdata = lt ? cv_q : last_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd0_q <= mem[raddr0];
		rd1_q <= mem[raddr1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
			pos_q   <= '0;
			cidx_q  <= '0;
			val_q   <= '0;
			top_q   <= '0;
			last_q  <= '0;
			cv_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				H_IDLE: begin
					if (cmd.start) begin
						val_q <= cmd.value;
						if (cmd.pop) begin
							count_q <= count_q - CNT_W'(1);
							pos_q   <= '0;
							state_q <= H_POP_RD;
						end else begin
							pos_q   <= count_q[IDX_W-1:0];
							count_q <= count_q + CNT_W'(1);
							state_q <= H_PUSH_CHK;
						end
					end
				end
				H_PUSH_CHK: begin
					if (pos_q == '0) begin
						done_q  <= 1'b1;
						state_q <= H_IDLE;
					end else begin
						state_q <= H_PUSH_CMP;
					end
				end
				H_PUSH_CMP: begin
					if (lt) begin
						pos_q   <= parent;
						state_q <= H_PUSH_CHK;
					end else begin
						done_q  <= 1'b1;
						state_q <= H_IDLE;
					end
				end
				H_POP_RD: begin
					state_q <= H_POP_LD;
				end
				H_POP_LD: begin
					top_q   <= rd0_q;
					last_q  <= rd1_q;
					state_q <= H_DN_CHK;
				end
				H_DN_CHK: begin
					if (child >= count_x) begin
						done_q  <= 1'b1;
						state_q <= H_IDLE;
					end else begin
						cidx_q  <= child[IDX_W-1:0];
						state_q <= H_DN_SEL;
					end
				end
				H_DN_SEL: begin
					if ((child_r < count_x) && lt) begin
						cv_q   <= rd1_q;
						cidx_q <= child_r[IDX_W-1:0];
					end else begin
						cv_q <= rd0_q;
					end
					state_q <= H_DN_CMP;
				end
				H_DN_CMP: begin
					if (lt) begin
						pos_q   <= cidx_q;
						state_q <= H_DN_CHK;
					end else begin
						done_q  <= 1'b1;
						state_q <= H_IDLE;
					end
				end
				default: begin
					state_q <= H_IDLE;
				end
			endcase
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = top_q;
	assign rsp.count = count_q;

endmodule

/* sv/smallest_free_id_allocator.sv */
// ----------------------------------------------------------------------------
// smallest_free_id_allocator: smallest free identifier allocator
// Grants the smallest free id from a high-water counter or a heap of
// released ids; each request gives one grant/status response.
// ----------------------------------------------------------------------------
// Timing: counter grants and rejected requests go from the pending register
// to the output register that drives m_tvalid, waiting while it is stalled;
// releases and heap grants first wait for the heap engine's sift to finish.
// Throughput: one request at a time; s_tready is low while one is in work.
// Reset: counter and heap count cleared, total_seats back to 1024; heap
// memory needs no clearing, only entries below the count are read.
module smallest_free_id_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [sfia_pkg::SEAT_W-1:0] cfg_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,  // [10:0] seat_number
	input  logic                        s_tuser,  // [0] mode
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [15:0]                 m_tdata,  // [10:0] granted_seat
	output logic [1:0]                  m_tuser   // [1:0] status
);
	import sfia_pkg::*;

	logic [SEAT_W-1:0] total_q;
	logic [SEAT_W-1:0] hw_q;
	logic              busy_q;
	logic              pop_q;
	logic              pend_q;
	logic [SEAT_W-1:0] pgrant_q;
	logic [1:0]        pstat_q;
	logic              mvalid_q;
	logic [SEAT_W-1:0] grant_q;
	logic [1:0]        stat_q;

	heap_cmd_t heap_cmd;
	heap_rsp_t heap_rsp;

	logic accept;
	logic heap_empty;
	logic heap_full;
	logic hw_ok;
	logic out_free;

	assign accept     = s_tvalid && s_tready;
	assign heap_empty = (heap_rsp.count == '0);
	assign heap_full  = (heap_rsp.count == CNT_W'(MAX_SEATS));
	assign hw_ok      = (LIM_W'(hw_q) < LIM_W'(total_q)) &&
	                    (LIM_W'(hw_q) < LIM_W'(MAX_SEATS));
	assign out_free   = !mvalid_q || m_tready;

	assign heap_cmd.start = accept && ((s_tuser == MODE_RESERVE) ? !heap_empty : !heap_full);
	assign heap_cmd.pop   = (s_tuser == MODE_RESERVE);
	assign heap_cmd.value = s_tdata[SEAT_W-1:0];

	sfia_heap u_heap (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (heap_cmd),
		.rsp    (heap_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= SEAT_W'(1024);
			hw_q     <= '0;
			busy_q   <= 1'b0;
			pop_q    <= 1'b0;
			pend_q   <= 1'b0;
			pgrant_q <= '0;
			pstat_q  <= ST_OK;
			mvalid_q <= 1'b0;
			grant_q  <= '0;
			stat_q   <= ST_OK;
		end else begin
			if (cfg_we) begin
				total_q <= cfg_wdata;
			end
			if (pend_q && out_free) begin
				mvalid_q <= 1'b1;
				grant_q  <= pgrant_q;
				stat_q   <= pstat_q;
				pend_q   <= 1'b0;
				busy_q   <= 1'b0;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
			if (accept) begin
				busy_q <= 1'b1;
				pop_q  <= heap_cmd.pop;
				if (!heap_cmd.start) begin
					pend_q   <= 1'b1;
					pgrant_q <= '0;
					if (s_tuser == MODE_RELEASE) begin
						pstat_q <= ST_HEAP_FULL;
					end else if (hw_ok) begin
						hw_q     <= hw_q + SEAT_W'(1);
						pgrant_q <= hw_q + SEAT_W'(1);
						pstat_q  <= ST_OK;
					end else begin
						pstat_q <= ST_EXHAUSTED;
					end
				end
			end
			if (heap_rsp.done) begin
				pend_q   <= 1'b1;
				pgrant_q <= pop_q ? heap_rsp.value : '0;
				pstat_q  <= ST_OK;
			end
		end
	end

	assign s_tready = !busy_q;
	assign m_tvalid = mvalid_q;
	assign m_tdata  = 16'(grant_q);
	assign m_tuser  = stat_q;

endmodule

/* sim/tb_smallest_free_id_allocator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_smallest_free_id_allocator: self-checking bench for the id allocator
// Drives reserve and release requests with random gaps and stalls. It keeps
// a seat pool model (counter plus a multiset of released ids) to predict each
// grant and status, checks every response in order, and steps total_seats
// through zero, one, small, shrunk, 1024 and above-range settings. One phase
// fills the release heap to overflow, and another runs the counter dry at 1024.
// ----------------------------------------------------------------------------
module tb_smallest_free_id_allocator;
	import sfia_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;

	typedef struct packed {
		logic [SEAT_W-1:0] seat;
		logic [1:0]        status;
	} seat_grant_t;

	class seat_pool_model;
		logic [SEAT_W-1:0] total_seats;
		logic [SEAT_W-1:0] high_water;
		logic [SEAT_W-1:0] released[$];
		seat_grant_t       pending[$];
		int                mismatches;

		function new();
			total_seats = 11'd1024;
			high_water  = '0;
			mismatches  = 0;
		endfunction

		function void take_request(logic mode, logic [SEAT_W-1:0] seat);
			seat_grant_t g;
			int          limit;
			int          low_idx;
			g.seat   = '0;
			g.status = ST_OK;
			if (mode == MODE_RESERVE) begin
				limit = (total_seats > MAX_SEATS) ? MAX_SEATS : total_seats;
				if (released.size() > 0) begin
					low_idx = 0;
					foreach (released[i])
						if (released[i] < released[low_idx])
							low_idx = i;
					g.seat = released[low_idx];
					released.delete(low_idx);
				end else if (high_water < limit) begin
					high_water++;
					g.seat = high_water;
				end else begin
					g.status = ST_EXHAUSTED;
				end
			end else if (released.size() >= MAX_SEATS) begin
				g.status = ST_HEAP_FULL;
			end else begin
				released.push_back(seat);
			end
			pending.push_back(g);
		endfunction

		function void check_grant(logic [SEAT_W-1:0] seat, logic [1:0] status);
			seat_grant_t g;
			if (pending.size() == 0) begin
				$error("unexpected response: granted_seat %0d status %0d", seat, status);
				mismatches++;
				return;
			end
			g = pending.pop_front();
			if (seat !== g.seat) begin
				$error("granted_seat: expected %0d, got %0d", g.seat, seat);
				mismatches++;
			end
			if (status !== g.status) begin
				$error("status: expected %0d, got %0d", g.status, status);
				mismatches++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [SEAT_W-1:0] cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [15:0]       s_tdata;  // [10:0] seat_number
	logic              s_tuser;  // [0] mode
	logic              m_tvalid;
	logic              m_tready;
	logic [15:0]       m_tdata;  // [10:0] granted_seat
	logic [1:0]        m_tuser;  // [1:0] status

	seat_pool_model    ledger = new();
	logic [SEAT_W-1:0] held[$];
	bit                steady;
	int                cycles;

	smallest_free_id_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_request(input logic mode, input logic [SEAT_W-1:0] seat);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {{(16 - SEAT_W){1'b0}}, seat};
		do @(posedge clk); while (!s_tready);
		ledger.take_request(mode, seat);
		if (mode == MODE_RESERVE && ledger.pending[$].status == ST_OK)
			held.push_back(ledger.pending[$].seat);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (ledger.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_total(input logic [SEAT_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		ledger.total_seats = value;
	endtask

	task automatic run_mix(input int count, input int reserve_pct);
		int                idx;
		logic [SEAT_W-1:0] seat;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < reserve_pct) begin
				send_request(MODE_RESERVE, SEAT_W'($urandom_range(0, 2047)));
			end else begin
				if (held.size() > 0 && $urandom_range(0, 99) < 80) begin
					idx  = $urandom_range(0, held.size() - 1);
					seat = held[idx];
					held.delete(idx);
				end else begin
					seat = SEAT_W'($urandom_range(0, 2047));
				end
				send_request(MODE_RELEASE, seat);
			end
			if ($urandom_range(0, 99) < 3)
				wait_idle();
		end
	endtask

	// response side: random backpressure, checks on every accepted response
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				ledger.check_grant(m_tdata[SEAT_W-1:0], m_tuser);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [SEAT_W-1:0] mix_totals[9];
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= MODE_RESERVE;
		steady    = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: counter grants, odd and duplicate releases, heap order
		repeat (3) send_request(MODE_RESERVE, 11'd0);
		send_request(MODE_RELEASE, 11'd2);
		send_request(MODE_RELEASE, 11'd0);
		send_request(MODE_RELEASE, 11'd2047);
		send_request(MODE_RELEASE, 11'd2);
		send_request(MODE_RELEASE, 11'd1024);
		repeat (6) send_request(MODE_RESERVE, 11'h7ff);
		wait_idle();
		// limit shrunk below high water
		write_total(11'd3);
		send_request(MODE_RESERVE, 11'd0);
		send_request(MODE_RELEASE, 11'd3);
		send_request(MODE_RESERVE, 11'd0);
		send_request(MODE_RESERVE, 11'd0);
		wait_idle();
		// no seats at all
		write_total(11'd0);
		send_request(MODE_RESERVE, 11'd0);
		send_request(MODE_RELEASE, 11'd7);
		send_request(MODE_RESERVE, 11'd0);
		wait_idle();
		write_total(11'd2047);
		send_request(MODE_RESERVE, 11'd0);
		wait_idle();

		mix_totals[0] = 11'd1024;
		mix_totals[1] = 11'd1;
		mix_totals[2] = 11'd2047;
		mix_totals[3] = SEAT_W'($urandom_range(1, 1024));
		mix_totals[4] = 11'd0;
		mix_totals[5] = SEAT_W'($urandom_range(2, 40));
		mix_totals[6] = SEAT_W'($urandom_range(0, 2047));
		mix_totals[7] = 11'd2;
		mix_totals[8] = 11'd1024;
		foreach (mix_totals[p]) begin
			steady = ($urandom_range(0, 3) == 0);
			write_total(mix_totals[p]);
			run_mix(60, $urandom_range(35, 70));
			wait_idle();
		end

		// fill the release heap past capacity, then drain it
		steady = 1'b0;
		write_total(11'd1024);
		while (ledger.released.size() < MAX_SEATS)
			send_request(MODE_RELEASE, SEAT_W'($urandom_range(0, 2047)));
		repeat (3) send_request(MODE_RELEASE, SEAT_W'($urandom_range(0, 2047)));
		wait_idle();
		while (ledger.released.size() > 0)
			send_request(MODE_RESERVE, 11'd0);
		wait_idle();

		// run the counter dry at the full limit
		held.delete();
		do begin
			send_request(MODE_RESERVE, 11'd0);
		end while (ledger.pending[$].status != ST_EXHAUSTED);
		send_request(MODE_RESERVE, 11'd0);
		wait_idle();

		write_total(11'd1);
		run_mix(30, 50);
		wait_idle();
		repeat (40) @(posedge clk);

		if (ledger.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
